// File: rtl/neighbour_table_with_aging_macros.svh
// ----------------------------------------------------------------------------
// neighbour_table_with_aging_macros.svh
// assertion macros for the neighbour table, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_TABLE_WITH_AGING_MACROS_SVH
`define NEIGHBOUR_TABLE_WITH_AGING_MACROS_SVH

`ifndef SYNTHESIS

// consequent checked in the same cycle as the antecedent
`define NTA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("neighbour table assertion failed");

// consequent checked in the cycle after the antecedent
`define NTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("neighbour table assertion failed");

`else

`define NTA_ASSERT_SAME(label, ante, cons)
`define NTA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// shared types, constants and indicator tables of the neighbour table
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int TABLE_DEPTH = 5;
  localparam int CNT_W       = 3;
  localparam int ID_W        = 8;
  localparam int AGE_W       = 8;
  localparam int DIST_W      = 8;
  localparam int LVL_W       = 2;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [AGE_W-1:0]  TIMEOUT_RESET = 8'd50;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 8'd100;
  localparam logic [AGE_W-1:0]  AGE_MAX = 8'hFF;

  typedef enum logic [0:0] {
    REG_TIMEOUT  = 1'b0,
    REG_MAX_DIST = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    FUNC_MESSAGE = 1'b0,
    FUNC_TICK    = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SCAN,
    ST_APPEND,
    ST_AGE,
    ST_DONE
  } st_t;

  // result handed from the engine to the output register
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } eng_res_t;

  function automatic logic [LVL_W-1:0] red_of(input logic [CNT_W-1:0] cnt);
    logic [LVL_W-1:0] lvl;
    case (cnt)
      3'd0:    lvl = 2'd0;
      3'd1:    lvl = 2'd1;
      3'd2:    lvl = 2'd1;
      3'd3:    lvl = 2'd2;
      default: lvl = 2'd3;
    endcase
    return lvl;
  endfunction

  function automatic logic [LVL_W-1:0] green_of(input logic [CNT_W-1:0] cnt);
    logic [LVL_W-1:0] lvl;
    case (cnt)
      3'd0:    lvl = 2'd3;
      3'd1:    lvl = 2'd3;
      3'd2:    lvl = 2'd2;
      3'd3:    lvl = 2'd1;
      3'd4:    lvl = 2'd1;
      default: lvl = 2'd0;
    endcase
    return lvl;
  endfunction

endpackage

// File: rtl/nta_channels.sv
// ----------------------------------------------------------------------------
// nta_channels
// valid/ready channels for incoming requests and results
// ----------------------------------------------------------------------------
interface nta_item_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [nta_pkg::ID_W-1:0]   sender_id;
  logic [nta_pkg::DIST_W-1:0] distance;

  modport source (output valid, func, sender_id, distance, input ready);
  modport sink   (input valid, func, sender_id, distance, output ready);
endinterface

interface nta_result_if;
  logic                      valid;
  logic                      ready;
  logic [nta_pkg::CNT_W-1:0] neighbour_count;
  logic [nta_pkg::LVL_W-1:0] red_level;
  logic [nta_pkg::LVL_W-1:0] green_level;

  modport source (output valid, neighbour_count, red_level, green_level, input ready);
  modport sink   (input valid, neighbour_count, red_level, green_level, output ready);
endinterface

// File: rtl/nta_cfg.sv
// ----------------------------------------------------------------------------
// nta_cfg
// apb register bank: timeout and distance limit
// ----------------------------------------------------------------------------
module nta_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nta_pkg::ADDR_W-1:0]  paddr,
  input  logic [nta_pkg::DATA_W-1:0]  pwdata,
  output logic [nta_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [nta_pkg::AGE_W-1:0]   timeout_ticks,
  output logic [nta_pkg::DIST_W-1:0]  max_distance
);

  nta_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = nta_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= nta_pkg::TIMEOUT_RESET;
      max_distance  <= nta_pkg::MAX_DIST_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        nta_pkg::REG_TIMEOUT:  timeout_ticks <= pwdata[nta_pkg::AGE_W-1:0];
        nta_pkg::REG_MAX_DIST: max_distance  <= pwdata[nta_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nta_pkg::REG_TIMEOUT:
        prdata = {{(nta_pkg::DATA_W-nta_pkg::AGE_W){1'b0}}, timeout_ticks};
      nta_pkg::REG_MAX_DIST:
        prdata = {{(nta_pkg::DATA_W-nta_pkg::DIST_W){1'b0}}, max_distance};
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: rtl/nta_engine.sv
// ----------------------------------------------------------------------------
// nta_engine
// table storage, one shared comparator and the sequencer that walks entries
// ----------------------------------------------------------------------------
module nta_engine #(
  parameter int TableDepth = nta_pkg::TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        func,
  input  logic [nta_pkg::ID_W-1:0]    sender_id,
  input  logic [nta_pkg::DIST_W-1:0]  distance,
  input  logic [nta_pkg::AGE_W-1:0]   timeout_ticks,
  input  logic [nta_pkg::DIST_W-1:0]  max_distance,
  input  logic                        res_free,
  output logic                        ready,
  output nta_pkg::eng_res_t           res
);

  localparam int CW   = nta_pkg::CNT_W;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [CW-1:0] DepthC = CW'(TableDepth);

  nta_pkg::st_t state, state_next;

  logic [CW-1:0]              ptr, kept, count;
  logic [nta_pkg::ID_W-1:0]   id_q;
  logic [nta_pkg::DIST_W-1:0] dist_q;

  logic [nta_pkg::ID_W-1:0]  id_mem  [TableDepth];
  logic [nta_pkg::AGE_W-1:0] age_mem [TableDepth];

  logic [nta_pkg::ID_W-1:0]  rd_id;
  logic [nta_pkg::AGE_W-1:0] rd_age, age_inc;
  logic                      in_range;

  // shared compare unit
  logic [7:0] op_a, op_b;
  logic       cmp_eq, cmp_lt;

  // control from the output decoder
  logic                      wr_en;
  logic [IdxW-1:0]           wr_idx;
  logic [nta_pkg::ID_W-1:0]  wr_id;
  logic [nta_pkg::AGE_W-1:0] wr_age;
  logic                      ptr_inc, kept_inc, count_load;
  logic [CW-1:0]             count_next;

  assign rd_id    = id_mem[ptr[IdxW-1:0]];
  assign rd_age   = age_mem[ptr[IdxW-1:0]];
  assign age_inc  = (rd_age == nta_pkg::AGE_MAX) ? rd_age : rd_age + 8'd1;
  assign in_range = ptr < count;

  assign cmp_eq = op_a == op_b;
  assign cmp_lt = op_a < op_b;

  assign ready     = state == nta_pkg::ST_IDLE;
  assign res.valid = (state == nta_pkg::ST_DONE) && res_free;
  assign res.count = count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nta_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (func == nta_pkg::FUNC_TICK) ? nta_pkg::ST_AGE : nta_pkg::ST_RANGE;
        end
      end
      nta_pkg::ST_RANGE:  state_next = cmp_lt ? nta_pkg::ST_SCAN : nta_pkg::ST_DONE;
      nta_pkg::ST_SCAN: begin
        if (!in_range) begin
          state_next = nta_pkg::ST_APPEND;
        end else if (cmp_eq) begin
          state_next = nta_pkg::ST_DONE;
        end
      end
      nta_pkg::ST_APPEND: state_next = nta_pkg::ST_DONE;
      nta_pkg::ST_AGE: begin
        if (!in_range) begin
          state_next = nta_pkg::ST_DONE;
        end
      end
      nta_pkg::ST_DONE: begin
        if (res_free) begin
          state_next = nta_pkg::ST_IDLE;
        end
      end
      default: state_next = nta_pkg::ST_IDLE;
    endcase
  end

  // outputs: operand select and table writes
  always_comb begin
    op_a       = '0;
    op_b       = '0;
    wr_en      = 1'b0;
    wr_idx     = ptr[IdxW-1:0];
    wr_id      = rd_id;
    wr_age     = '0;
    ptr_inc    = 1'b0;
    kept_inc   = 1'b0;
    count_load = 1'b0;
    count_next = count;
    case (state)
      nta_pkg::ST_RANGE: begin
        op_a = dist_q;
        op_b = max_distance;
      end
      nta_pkg::ST_SCAN: begin
        op_a    = rd_id;
        op_b    = id_q;
        ptr_inc = in_range;
        if (in_range && cmp_eq) begin
          wr_en = 1'b1;
        end
      end
      nta_pkg::ST_APPEND: begin
        if (count < DepthC) begin
          wr_en      = 1'b1;
          wr_idx     = count[IdxW-1:0];
          wr_id      = id_q;
          count_load = 1'b1;
          count_next = count + CW'(1);
        end
      end
      nta_pkg::ST_AGE: begin
        op_a = age_inc;
        op_b = timeout_ticks;
        if (in_range) begin
          ptr_inc = 1'b1;
          if (cmp_lt) begin
            wr_en    = 1'b1;
            wr_idx   = kept[IdxW-1:0];
            wr_age   = age_inc;
            kept_inc = 1'b1;
          end
        end else begin
          count_load = 1'b1;
          count_next = kept;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nta_pkg::ST_IDLE;
      count <= '0;
      ptr   <= '0;
      kept  <= '0;
    end else begin
      state <= state_next;
      if (count_load) begin
        count <= count_next;
      end
      if (start && ready) begin
        ptr  <= '0;
        kept <= '0;
      end else begin
        if (ptr_inc) begin
          ptr <= ptr + CW'(1);
        end
        if (kept_inc) begin
          kept <= kept + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && ready) begin
      id_q   <= sender_id;
      dist_q <= distance;
    end
    if (wr_en) begin
      id_mem[wr_idx]  <= wr_id;
      age_mem[wr_idx] <= wr_age;
    end
  end

endmodule

// File: rtl/neighbour_table_with_aging.sv
// ----------------------------------------------------------------------------
// neighbour_table_with_aging
// neighbour table of up to TableDepth ids with per-entry age and timeout
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  item      in    valid/ready     func, sender_id, distance
//  result    out   valid/ready     neighbour_count, red_level, green_level
//  apb       in    psel/penable    paddr, pwdata, prdata (pready always high)
//
//  one request at a time; the engine walks the table one entry per cycle
//  through a single shared 8-bit comparator
//  message: a range check (ending there when out of range), then a scan
//  that ends on a hit, resetting its age, or an append on a miss (dropped
//  when the table is full); tick: one pass that ages and packs the entries
//  the result then waits in an output register, so the next request is taken
//  while an earlier result is still stalled
//  rst (synchronous) empties the table and restores timeout 50, limit 100
`include "neighbour_table_with_aging_macros.svh"

module neighbour_table_with_aging #(
  parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  nta_item_if.sink                    item,
  nta_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nta_pkg::ADDR_W-1:0]  paddr,
  input  logic [nta_pkg::DATA_W-1:0]  pwdata,
  output logic [nta_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CW = nta_pkg::CNT_W;

  logic [nta_pkg::AGE_W-1:0]  timeout_ticks;
  logic [nta_pkg::DIST_W-1:0] max_distance;

  logic              eng_ready;
  logic              start;
  logic              res_free;
  nta_pkg::eng_res_t eng_res;

  // output register parting the engine from the result consumer
  logic          out_valid;
  logic [CW-1:0] out_count;

  // config registers behind the apb port
  nta_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks),
    .max_distance  (max_distance)
  );

  assign item.ready = eng_ready;
  assign start      = item.valid && eng_ready;

  // output register is free when empty or being drained this cycle
  assign res_free = !out_valid || result.ready;

  nta_engine #(
    .TableDepth (TABLE_DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (item.func),
    .sender_id     (item.sender_id),
    .distance      (item.distance),
    .timeout_ticks (timeout_ticks),
    .max_distance  (max_distance),
    .res_free      (res_free),
    .ready         (eng_ready),
    .res           (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res.valid) begin
      out_count <= eng_res.count;
    end
  end

  // indicator levels come straight from the stored count
  assign result.valid           = out_valid;
  assign result.neighbour_count = out_count;
  assign result.red_level       = nta_pkg::red_of(out_count);
  assign result.green_level     = nta_pkg::green_of(out_count);

  // table never holds more entries than its depth
  `NTA_ASSERT_SAME(a_count_bound, eng_res.valid, eng_res.count <= CW'(TABLE_DEPTH))
  // an accepted request keeps the engine busy for at least the next cycle
  `NTA_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
  // engine only hands over a result when the output register can take it
  `NTA_ASSERT_SAME(a_no_overwrite, eng_res.valid, !out_valid || result.ready)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the neighbour table against a predictor of its own: directed
// requests for the edge cases, then random message and tick traffic under
// several timeout and distance-limit settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb;
  import nta_pkg::*;

  // request as offered on the item channel
  typedef struct packed {
    func_t             func;
    logic [ID_W-1:0]   sender_id;
    logic [DIST_W-1:0] distance;
  } request_t;

  // what one result carries
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
  } reading_t;

  // indicator levels for counts 0..7, two bits per count, count 0 in the low bits
  localparam logic [15:0] RED_BY_COUNT   = {2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0};
  localparam logic [15:0] GREEN_BY_COUNT = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3};

  localparam int unsigned MAX_GAP   = 12;
  localparam int unsigned LONG_HOLD = 120;  // cycles the result side holds off
  localparam int unsigned DRAIN     = 16;   // beyond the longest walk of a full table

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  nta_item_if   req_ch ();
  nta_result_if res_ch ();

  neighbour_table_with_aging dut (
    .clk     (clk),
    .rst     (rst),
    .item    (req_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the table and of both limits
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   nb_id  [TABLE_DEPTH];
  logic [AGE_W-1:0]  nb_age [TABLE_DEPTH];
  int unsigned       nb_count;
  logic [AGE_W-1:0]  limit_age;
  logic [DIST_W-1:0] limit_dist;

  request_t pending_requests [$];   // filled by the stimulus, drained by the driver
  reading_t expected_readings [$];  // one per accepted request, oldest first

  // bookkeeping
  int unsigned requests_queued;
  int unsigned results_checked;
  int unsigned errors;
  int unsigned messages_sent;
  int unsigned ticks_sent;
  int unsigned ignored_far;
  int unsigned dropped_full;
  int unsigned refreshed;
  int unsigned aged_out;
  int unsigned full_seen;

  // idling knobs, set per phase by the stimulus
  bit          sender_gaps_on;
  bit          sink_stalls_on;
  int unsigned hold_asks;
  int unsigned hold_granted;

  // driver and monitor state
  request_t    in_flight;
  logic        req_offered;
  int unsigned gap_left;
  logic        res_ready_next;
  int unsigned stall_left;
  int unsigned hold_left;
  reading_t    want;

  // apply one accepted request to the table and work out the result it gives
  function automatic reading_t update_table(request_t r);
    reading_t    rd;
    int unsigned i;
    int unsigned kept;
    logic [AGE_W-1:0] age;
    bit          hit;
    if (r.func == FUNC_MESSAGE) begin
      messages_sent++;
      if (r.distance >= limit_dist) begin
        // at or beyond the limit the message does not count
        ignored_far++;
      end else begin
        // first matching entry wins; ids never repeat anyway
        hit = 1'b0;
        for (i = 0; i < nb_count; i++) begin
          if (!hit && nb_id[i] == r.sender_id) begin
            nb_age[i] = '0;
            hit = 1'b1;
          end
        end
        if (hit) begin
          refreshed++;
        end else if (nb_count < TABLE_DEPTH) begin
          nb_id[nb_count]  = r.sender_id;
          nb_age[nb_count] = '0;
          nb_count++;
        end else begin
          // no room left, the new id is lost
          dropped_full++;
        end
      end
    end else begin
      ticks_sent++;
      // age everything, saturating, then close up the gaps left by timed-out entries
      kept = 0;
      for (i = 0; i < nb_count; i++) begin
        age = (nb_age[i] == AGE_MAX) ? AGE_MAX : nb_age[i] + 8'd1;
        if (age < limit_age) begin
          nb_id[kept]  = nb_id[i];
          nb_age[kept] = age;
          kept++;
        end else begin
          aged_out++;
        end
      end
      nb_count = kept;
    end
    if (nb_count == TABLE_DEPTH) full_seen++;
    rd.count = nb_count[CNT_W-1:0];
    rd.red   = RED_BY_COUNT[2*nb_count +: 2];
    rd.green = GREEN_BY_COUNT[2*nb_count +: 2];
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending requests one by one, with an optional random gap after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      req_offered = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        // accepted at this edge: predict now, before anything else changes the table
        expected_readings.push_back(update_table(in_flight));
        req_offered = 1'b0;
        gap_left = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!req_offered) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          req_ch.func      <= in_flight.func;
          req_ch.sender_id <= in_flight.sender_id;
          req_ch.distance  <= in_flight.distance;
          req_offered = 1'b1;
        end
      end
      // valid is written once per edge, so a back-to-back request keeps it high
      req_ch.valid <= req_offered;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest expectation, may stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got count %0d red %0d green %0d",
                   $time, res_ch.neighbour_count, res_ch.red_level, res_ch.green_level);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (res_ch.neighbour_count !== want.count) begin
            $display("%0t: neighbour_count expected %0d, got %0d",
                     $time, want.count, res_ch.neighbour_count);
            errors++;
          end
          if (res_ch.red_level !== want.red) begin
            $display("%0t: red_level expected %0d, got %0d", $time, want.red, res_ch.red_level);
            errors++;
          end
          if (res_ch.green_level !== want.green) begin
            $display("%0t: green_level expected %0d, got %0d",
                     $time, want.green, res_ch.green_level);
            errors++;
          end
          results_checked++;
        end
        stall_left = sink_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      // a long hold-off lets the output register and the engine back up
      if (hold_granted != hold_asks) begin
        hold_granted = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready_next = 1'b0;
      end else begin
        res_ready_next = 1'b1;
      end
      res_ch.ready <= res_ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_request(func_t f, logic [ID_W-1:0] id, logic [DIST_W-1:0] d);
    request_t r;
    r.func      = f;
    r.sender_id = id;
    r.distance  = d;
    pending_requests.push_back(r);
    requests_queued++;
  endfunction

  // apb write: setup cycle, then access until pready is seen with penable
  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TIMEOUT) limit_age = value;
    else limit_dist = value;
  endtask

  // block is idle only once every queued request has come back
  task automatic wait_drained();
    while (results_checked < requests_queued) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_limits(logic [7:0] timeout, logic [7:0] dist_limit);
    wait_drained();
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_MAX_DIST, dist_limit);
  endtask

  // idling: bit 0 turns on sender gaps, bit 1 receiver stalls
  task automatic set_idling(int unsigned mode);
    sender_gaps_on = mode[0];
    sink_stalls_on = mode[1];
  endtask

  // mostly known ids from a small pool, in range, so the table fills, refreshes and
  // overflows; the rest ticks, far messages and random ids
  task automatic random_phase(logic [7:0] timeout, logic [7:0] dist_limit, int unsigned mode,
                              int unsigned n);
    logic [ID_W-1:0] pool [8];
    int unsigned k;
    int unsigned roll;
    set_limits(timeout, dist_limit);
    set_idling(mode);
    for (k = 0; k < 8; k++) pool[k] = ID_W'($urandom);
    hold_asks++;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        queue_request(FUNC_TICK, ID_W'($urandom), DIST_W'($urandom));
      end else if (roll < 85) begin
        queue_request(FUNC_MESSAGE, pool[$urandom_range(0, 7)],
                      DIST_W'((dist_limit == 0) ? $urandom
                                                : $urandom_range(0, dist_limit - 1)));
      end else if (roll < 93) begin
        queue_request(FUNC_MESSAGE, ID_W'($urandom), DIST_W'($urandom));
      end else begin
        queue_request(FUNC_MESSAGE, pool[$urandom_range(0, 7)],
                      DIST_W'($urandom_range(dist_limit, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_MESSAGE;
    req_ch.sender_id = '0;
    req_ch.distance = '0;
    res_ch.ready = 1'b0;
    nb_count = 0;
    limit_age = TIMEOUT_RESET;
    limit_dist = MAX_DIST_RESET;
    requests_queued = 0;
    results_checked = 0;
    errors = 0;
    messages_sent = 0;
    ticks_sent = 0;
    ignored_far = 0;
    dropped_full = 0;
    refreshed = 0;
    aged_out = 0;
    full_seen = 0;
    hold_asks = 0;
    hold_granted = 0;
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset limits: edge ids and distances, refresh, full table, drop
    set_idling(3);
    queue_request(FUNC_MESSAGE, 8'h00, 8'd0);
    queue_request(FUNC_MESSAGE, 8'hFF, 8'd99);     // just inside the limit
    queue_request(FUNC_MESSAGE, 8'h10, 8'd100);    // at the limit, ignored
    queue_request(FUNC_MESSAGE, 8'h11, 8'd255);
    queue_request(FUNC_MESSAGE, 8'h00, 8'd50);     // known id, age back to zero
    queue_request(FUNC_TICK, 8'hFF, 8'hFF);
    queue_request(FUNC_MESSAGE, 8'h01, 8'd1);
    queue_request(FUNC_MESSAGE, 8'h02, 8'd1);
    queue_request(FUNC_MESSAGE, 8'h03, 8'd1);      // table now full
    queue_request(FUNC_MESSAGE, 8'hAA, 8'd0);      // no room, dropped
    queue_request(FUNC_MESSAGE, 8'h03, 8'd2);      // hit on the last entry
    queue_request(FUNC_TICK, 8'h00, 8'h00);
    queue_request(FUNC_TICK, 8'h55, 8'hAA);

    // tight timeout with a zero distance limit: every message ignored, table ages out
    set_limits(8'd2, 8'd0);
    queue_request(FUNC_MESSAGE, 8'h55, 8'd0);
    queue_request(FUNC_TICK, 8'h00, 8'h00);
    queue_request(FUNC_MESSAGE, 8'h01, 8'd0);
    queue_request(FUNC_TICK, 8'h00, 8'h00);
    queue_request(FUNC_TICK, 8'h00, 8'h00);
    queue_request(FUNC_TICK, 8'h00, 8'h00);        // tick on an empty table

    // timeout of zero: one tick clears everything
    set_limits(8'd0, 8'd255);
    queue_request(FUNC_MESSAGE, 8'h80, 8'd254);
    queue_request(FUNC_MESSAGE, 8'h81, 8'd255);    // ignored even at the widest limit
    queue_request(FUNC_MESSAGE, 8'h82, 8'd10);
    queue_request(FUNC_MESSAGE, 8'h7F, 8'd10);
    queue_request(FUNC_TICK, 8'h00, 8'h00);

    // age saturation: with timeout 255 an entry leaves on the tick that takes it to 255
    set_limits(8'd255, 8'd255);
    set_idling(0);
    queue_request(FUNC_MESSAGE, 8'h3C, 8'd0);
    queue_request(FUNC_MESSAGE, 8'hC3, 8'd0);
    for (k = 0; k < 200; k++) queue_request(FUNC_TICK, ID_W'($urandom), DIST_W'($urandom));
    queue_request(FUNC_MESSAGE, 8'hC3, 8'd7);
    for (k = 0; k < 56; k++) queue_request(FUNC_TICK, ID_W'($urandom), DIST_W'($urandom));

    // random traffic under several settings; the first phase sends flat out
    // while the receiver holds off
    random_phase(8'd1, 8'd255, 2, 160);
    random_phase(8'd4, 8'd128, 3, 160);
    random_phase(8'd12, 8'd60, 1, 160);
    random_phase(8'($urandom_range(2, 30)), 8'($urandom_range(1, 255)), $urandom_range(0, 3), 160);
    random_phase(8'($urandom), 8'($urandom), $urandom_range(0, 3), 160);
    random_phase(8'd7, 8'd255, 0, 160);

    wait_drained();
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_readings.size());
      errors++;
    end
    $display("tb: %0d messages and %0d ticks, %0d results checked, table full %0d times",
             messages_sent, ticks_sent, results_checked, full_seen);
    $display("tb: %0d refreshed, %0d out of range, %0d dropped on a full table, %0d aged out",
             refreshed, ignored_far, dropped_full, aged_out);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/nta_pkg.sv
rtl/nta_channels.sv
rtl/nta_cfg.sv
rtl/nta_engine.sv
rtl/neighbour_table_with_aging.sv
verif/tb.sv
